[rtl/core/wlum_pkg.sv]
`timescale 1ns / 1ps
// Package for the weighted saturated luminance block.
// Holds the shared types and fixed constants; it depends on nothing else.
package wlum_pkg;

    // Operation codes carried by the op field of an input item.
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_ESTIMATE = 1'b1;

    // 255.0 in unsigned Q8.8: the ceiling for a gained cell mean.
    localparam logic [15:0] FULL_SCALE_Q8 = 16'd65280;

    // The quotient is resolved to 17 bits so that anything at or above 1.0 clamps.
    localparam int unsigned QUOT_BITS = 17;
    localparam logic [15:0] LUM_MAX   = 16'hFFFF;

    // Reset value of the cells-in-use register.
    localparam logic [7:0] CELLS_RESET = 8'd25;

    // Commands from the sequencer to the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;   // zero both sums
        logic scale;   // gain times mean, saturate, hold with the weight
        logic weigh;   // scaled mean times weight, add into the sums
    } t_mac_ctrl;

endpackage

[rtl/core/wlum_store.sv]
`timescale 1ns / 1ps
// Cell store: one 16-bit word per cell holding mean and weight.
// Single write port, single registered read port; no package use.
module wlum_store #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_mean,
    input  logic [7:0]        i_wr_weight,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_mean,
    output logic [7:0]        o_rd_weight
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {i_wr_mean, i_wr_weight};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_mean   = r_rd_data[15:8];
    assign o_rd_weight = r_rd_data[7:0];

endmodule

[rtl/core/wlum_mac.sv]
`timescale 1ns / 1ps
// Shared 16x8 multiplier with saturation and the two running sums.
// Depends on wlum_pkg for the control struct and the full-scale constant.
module wlum_mac #(
    parameter int Y_W = 32,
    parameter int W_W = 16
) (
    input  logic                i_clk,
    input  wlum_pkg::t_mac_ctrl i_ctrl,
    input  logic [15:0]         i_gain,
    input  logic [7:0]          i_mean,
    input  logic [7:0]          i_weight,
    output logic [Y_W-1:0]      o_ysum,
    output logic [W_W-1:0]      o_wsum
);

    logic [15:0]    r_s;
    logic [7:0]     r_w;
    logic [Y_W-1:0] r_ysum;
    logic [W_W-1:0] r_wsum;
    logic [15:0]    mul_a;
    logic [7:0]     mul_b;
    logic [23:0]    prod;

    // The one multiplier serves both products of a cell on alternate cycles.
    assign mul_a = i_ctrl.scale ? i_gain : r_s;
    assign mul_b = i_ctrl.scale ? i_mean : r_w;
    assign prod  = 24'(mul_a) * 24'(mul_b);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.scale) begin
            r_s <= (prod > 24'(wlum_pkg::FULL_SCALE_Q8)) ? wlum_pkg::FULL_SCALE_Q8
                                                         : prod[15:0];
            r_w <= i_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_ysum <= '0;
            r_wsum <= '0;
        end else if (i_ctrl.weigh) begin
            r_ysum <= r_ysum + Y_W'(prod);
            r_wsum <= r_wsum + W_W'(r_w);
        end
    end

    assign o_ysum = r_ysum;
    assign o_wsum = r_wsum;

endmodule

[rtl/core/wlum_div.sv]
`timescale 1ns / 1ps
// Restoring divider: round(Y * 256 / (W * 255)) as 17 quotient bits, clamped.
// Depends on wlum_pkg for the quotient length and clamp value.
module wlum_div #(
    parameter int Y_W = 32,
    parameter int W_W = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [Y_W-1:0] i_ysum,
    input  logic [W_W-1:0] i_wsum,
    output logic           o_done,
    output logic [15:0]    o_quot
);

    localparam int D_W   = W_W + 9;
    localparam int NUM_W = Y_W + 10;
    localparam int HI_W  = NUM_W - 17;
    localparam int RW    = ((HI_W > D_W) ? HI_W : D_W) + 1;
    localparam int QB    = wlum_pkg::QUOT_BITS;

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_PREP  = 2'd1;
    localparam logic [1:0] D_CHECK = 2'd2;
    localparam logic [1:0] D_ITER  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [4:0]       r_cnt;
    logic             r_done;
    logic             r_ovf;
    logic [D_W-1:0]   r_den;
    logic [Y_W-1:0]   r_y;
    logic [RW-1:0]    r_rem;
    logic [QB-1:0]    r_lo;
    logic [QB-1:0]    r_q;
    logic [NUM_W-1:0] num;
    logic [RW-1:0]    sh;
    logic [RW-1:0]    den_ext;
    logic             fits;

    // num = 512*Y + 255*W; the divisor kept in r_den is 2*255*W.
    assign num     = {1'b0, r_y, 9'd0} + NUM_W'(r_den[D_W-1:1]);
    assign den_ext = RW'(r_den);
    assign sh      = {r_rem[RW-2:0], r_lo[QB-1]};
    assign fits    = (sh >= den_ext);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_start) n_state = D_PREP;
            D_PREP:  n_state = D_CHECK;
            D_CHECK: n_state = D_ITER;
            D_ITER:  if (r_cnt == 5'(QB - 1)) n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == D_ITER) && (r_cnt == 5'(QB - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    r_den <= {i_wsum, 9'd0} - {8'd0, i_wsum, 1'b0};
                    r_y   <= i_ysum;
                end
            end
            D_PREP: begin
                r_rem <= RW'(num >> QB);
                r_lo  <= num[QB-1:0];
            end
            D_CHECK: begin
                // A top part already at or above the divisor means q >= 2^17.
                r_ovf <= (r_rem >= den_ext);
                r_cnt <= '0;
            end
            D_ITER: begin
                r_rem <= fits ? (sh - den_ext) : sh;
                r_q   <= {r_q[QB-2:0], fits};
                r_lo  <= {r_lo[QB-2:0], 1'b0};
                r_cnt <= r_cnt + 5'd1;
            end
            default: begin
            end
        endcase
    end

    assign o_done = r_done;
    assign o_quot = (r_ovf || r_q[QB-1]) ? wlum_pkg::LUM_MAX : r_q[15:0];

endmodule

[rtl/core/weighted_saturated_luminance.sv]
`timescale 1ns / 1ps
// Weighted saturated luminance: a load item writes one cell; an estimate item walks
// cells 0 to n-1 (n = cells_in_use, capped at MAX_CELLS) through one shared 16x8
// multiplier, a scale step and a weigh step per cell, then runs a 17-step restoring
// divider, which a zero weight sum skips. Input stall stays high while an estimate
// is in progress; the result register lets a finished item wait downstream.
// Uses wlum_pkg, wlum_store, wlum_mac and wlum_div.
module weighted_saturated_luminance #(
    parameter int MAX_CELLS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [6:0]  i_cell_index,
    input  logic [7:0]  i_cell_mean,
    input  logic [7:0]  i_cell_weight,
    input  logic [15:0] i_gain,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_luminance,
    output logic        o_no_weight,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int ADDR_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);
    localparam int W_W    = 8 + CNT_W;
    localparam int Y_W    = 24 + CNT_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_SCALE  = 3'd2;
    localparam logic [2:0] S_WEIGH  = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_DIV    = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [7:0]          r_cells;
    logic [CNT_W-1:0]    r_n;
    logic [CNT_W-1:0]    r_idx;
    logic [15:0]         r_gain;
    logic [15:0]         r_lum;
    logic                r_flag;
    logic                r_out_valid;
    logic [15:0]         r_out_lum;
    logic                r_out_flag;

    logic                in_acc;
    logic                out_free;
    logic [CNT_W-1:0]    n_cap;
    logic [15:0]         idx_ext;
    logic                wr_en;
    logic [7:0]          rd_mean;
    logic [7:0]          rd_weight;
    logic [Y_W-1:0]      ysum;
    logic [W_W-1:0]      wsum;
    logic                div_start;
    logic                div_done;
    logic [15:0]         div_quot;
    wlum_pkg::t_mac_ctrl mac_ctrl;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign n_cap   = (9'(r_cells) > 9'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(r_cells);
    assign idx_ext = 16'(i_cell_index);
    assign wr_en   = in_acc && (i_op == wlum_pkg::OP_LOAD)
                     && (9'(i_cell_index) < 9'(MAX_CELLS));

    assign mac_ctrl.clear = in_acc && (i_op == wlum_pkg::OP_ESTIMATE);
    assign mac_ctrl.scale = (r_state == S_SCALE);
    assign mac_ctrl.weigh = (r_state == S_WEIGH);
    assign div_start      = (r_state == S_CHECK) && (wsum != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= wlum_pkg::CELLS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cells <= i_cfg_data;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_op == wlum_pkg::OP_ESTIMATE)) begin
                    n_state = (n_cap == '0) ? S_CHECK : S_FETCH;
                end
            end
            S_FETCH: n_state = S_SCALE;
            S_SCALE: n_state = S_WEIGH;
            S_WEIGH: n_state = (r_idx == r_n) ? S_CHECK : S_SCALE;
            S_CHECK: n_state = (wsum == '0) ? S_FINISH : S_DIV;
            S_DIV:   if (div_done) n_state = S_FINISH;
            S_FINISH: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_n   <= '0;
        end else if (mac_ctrl.clear) begin
            r_idx <= '0;
            r_n   <= n_cap;
        end else if (r_state == S_SCALE) begin
            // Advancing here lets the store fetch the next cell during the weigh cycle.
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mac_ctrl.clear) begin
            r_gain <= i_gain;
        end
        if (r_state == S_CHECK) begin
            r_flag <= (wsum == '0);
            r_lum  <= '0;
        end else if ((r_state == S_DIV) && div_done) begin
            r_lum <= div_quot;
        end
        if ((r_state == S_FINISH) && out_free) begin
            r_out_lum  <= r_lum;
            r_out_flag <= r_flag;
        end
    end

    wlum_store #(
        .DEPTH  (MAX_CELLS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (idx_ext[ADDR_W-1:0]),
        .i_wr_mean   (i_cell_mean),
        .i_wr_weight (i_cell_weight),
        .i_rd_addr   (r_idx[ADDR_W-1:0]),
        .o_rd_mean   (rd_mean),
        .o_rd_weight (rd_weight)
    );

    wlum_mac #(
        .Y_W (Y_W),
        .W_W (W_W)
    ) u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_gain   (r_gain),
        .i_mean   (rd_mean),
        .i_weight (rd_weight),
        .o_ysum   (ysum),
        .o_wsum   (wsum)
    );

    wlum_div #(
        .Y_W (Y_W),
        .W_W (W_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_ysum  (ysum),
        .i_wsum  (wsum),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_luminance = r_out_lum;
    assign o_no_weight = r_out_flag;

    // A zero weight sum always comes out as zero luminance.
    a_no_weight_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_no_weight |-> o_luminance == 16'd0)
        else $error("no_weight result with non-zero luminance");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide phase");

    // The cell walk never runs past the captured cell count.
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> r_idx <= r_n)
        else $error("cell index beyond cells in use");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for weighted_saturated_luminance: loads exposure cells and requests
// estimates under random source gaps and sink stalls, checking each result against a predictor.
// Depends on wlum_pkg and the weighted_saturated_luminance RTL.
module tb;

    localparam int CELL_COUNT    = 128;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int PHASE_ITEMS   = 150;
    localparam int PHASE_COUNT   = 9;

    typedef struct packed {
        logic [15:0] luminance;
        logic        no_weight;
    } t_lum_result;

    // Mirrors the cell store and the cell count, and queues the estimates still owed.
    class metering_model;
        logic [7:0]  cells;
        logic [7:0]  mean_copy [CELL_COUNT];
        logic [7:0]  weight_copy [CELL_COUNT];
        t_lum_result lum_due [$];
        int          mismatch_count;

        function new();
            cells = wlum_pkg::CELLS_RESET;
            mismatch_count = 0;
            foreach (mean_copy[i]) begin
                mean_copy[i] = 8'd0;
                weight_copy[i] = 8'd0;
            end
        endfunction

        function t_lum_result weighted_lum(logic [15:0] gain);
            t_lum_result     r;
            longint unsigned ysum;
            longint unsigned wsum;
            longint unsigned den;
            longint unsigned quot;
            int unsigned     scaled;
            int              n;
            ysum = 0;
            wsum = 0;
            n = (cells > CELL_COUNT) ? CELL_COUNT : int'(cells);
            for (int i = 0; i < n; i++) begin
                scaled = 32'(mean_copy[i]) * 32'(gain);
                if (scaled > 32'(wlum_pkg::FULL_SCALE_Q8))
                    scaled = 32'(wlum_pkg::FULL_SCALE_Q8);
                ysum += 64'(scaled) * 64'(weight_copy[i]);
                wsum += 64'(weight_copy[i]);
            end
            if (wsum == 0) begin
                r.luminance = 16'd0;
                r.no_weight = 1'b1;
            end else begin
                // Round to nearest: (Y * 256 / (W * 255)) with half a step added.
                den = wsum * 255;
                quot = (ysum * 512 + den) / (den * 2);
                r.luminance = (quot > wlum_pkg::LUM_MAX) ? wlum_pkg::LUM_MAX : quot[15:0];
                r.no_weight = 1'b0;
            end
            return r;
        endfunction

        function void take_item(logic op, logic [6:0] idx, logic [7:0] mean,
                                logic [7:0] weight, logic [15:0] gain);
            if (op == wlum_pkg::OP_LOAD) begin
                mean_copy[idx] = mean;
                weight_copy[idx] = weight;
            end else begin
                lum_due.insert(lum_due.size(), weighted_lum(gain));
            end
        endfunction

        function void match_result(logic [15:0] lum, logic flag);
            t_lum_result want;
            if (lum_due.size() == 0) begin
                $display("%0t: unexpected estimate: luminance %0d no_weight %0d",
                         $time, lum, flag);
                mismatch_count++;
            end else begin
                want = lum_due.pop_front();
                if (want.luminance !== lum || want.no_weight !== flag) begin
                    $display({"%0t: estimate mismatch: expected luminance %0d no_weight %0d,",
                              " got luminance %0d no_weight %0d"},
                             $time, want.luminance, want.no_weight, lum, flag);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_op = wlum_pkg::OP_LOAD;
    logic [6:0]  i_cell_index = 7'd0;
    logic [7:0]  i_cell_mean = 8'd0;
    logic [7:0]  i_cell_weight = 8'd0;
    logic [15:0] i_gain = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_luminance;
    logic        o_no_weight;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'd0;

    metering_model meter;
    bit            cell_loaded [CELL_COUNT];
    int            send_idle_pct = 0;
    int            stall_pct = 0;
    int unsigned   cycle_count = 0;

    weighted_saturated_luminance #(
        .MAX_CELLS(CELL_COUNT)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_op(i_op),
        .i_cell_index(i_cell_index),
        .i_cell_mean(i_cell_mean),
        .i_cell_weight(i_cell_weight),
        .i_gain(i_gain),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_luminance(o_luminance),
        .o_no_weight(o_no_weight),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish in %0d cycles", $time, CYCLE_LIMIT);
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            meter.match_result(o_luminance, o_no_weight);
    end

    // Called just after a falling edge; returns just after the falling edge that
    // follows acceptance, leaving valid high for the caller to reuse or drop.
    task automatic send_item(logic op, logic [6:0] idx, logic [7:0] mean,
                             logic [7:0] weight, logic [15:0] gain);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op = op;
        i_cell_index = idx;
        i_cell_mean = mean;
        i_cell_weight = weight;
        i_gain = gain;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        meter.take_item(op, idx, mean, weight, gain);
        if (op == wlum_pkg::OP_LOAD)
            cell_loaded[idx] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic drain(int extra);
        i_in_valid = 1'b0;
        while (meter.lum_due.size() != 0)
            @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // A load leaves nothing to wait for, so the settle time covers a trailing one.
    task automatic write_cells(logic [7:0] value);
        drain(SETTLE_CYCLES);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        meter.cells = value;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 16'h01FF));
            2: return 16'($urandom_range(16'h00C0, 16'h0140));
            default: return 16'($urandom_range(0, 16'h0040));
        endcase
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [7:0] phase_cells [PHASE_COUNT];
        int         n;
        int         next_free;
        int         idx;
        bit         ready;

        meter = new();
        phase_cells = '{8'd4, 8'd128, 8'd1, 8'd255, 8'd40, 8'd129, 8'd2, 8'd0, 8'd128};
        phase_cells[7] = 8'($urandom);
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: a single cell first, then no cells, then two.
        write_cells(8'd1);
        send_item(wlum_pkg::OP_LOAD, 7'd0, 8'hFF, 8'hFF, 16'h0000);
        send_item(wlum_pkg::OP_ESTIMATE, 7'd0, 8'h00, 8'h00, 16'hFFFF);
        send_item(wlum_pkg::OP_ESTIMATE, 7'h7F, 8'hFF, 8'hFF, 16'h0000);
        send_item(wlum_pkg::OP_ESTIMATE, 7'd0, 8'h00, 8'h00, 16'h0100);
        send_item(wlum_pkg::OP_ESTIMATE, 7'd0, 8'h00, 8'h00, 16'h00FF);
        send_item(wlum_pkg::OP_LOAD, 7'd0, 8'h00, 8'h00, 16'hFFFF);
        send_item(wlum_pkg::OP_ESTIMATE, 7'd0, 8'h00, 8'h00, 16'h8000);
        send_item(wlum_pkg::OP_LOAD, 7'h7F, 8'h01, 8'h01, 16'h5555);
        send_item(wlum_pkg::OP_LOAD, 7'd0, 8'h01, 8'hFF, 16'hAAAA);
        send_item(wlum_pkg::OP_ESTIMATE, 7'h55, 8'hAA, 8'h55, 16'h0001);
        write_cells(8'd0);
        send_item(wlum_pkg::OP_ESTIMATE, 7'd0, 8'h00, 8'h00, 16'h0100);
        write_cells(8'd2);
        send_item(wlum_pkg::OP_LOAD, 7'd1, 8'h80, 8'h01, 16'h0000);
        send_item(wlum_pkg::OP_ESTIMATE, 7'd0, 8'h00, 8'h00, 16'h0180);
        send_item(wlum_pkg::OP_ESTIMATE, 7'd0, 8'h00, 8'h00, 16'hFFFF);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            write_cells(phase_cells[p]);
            send_idle_pct = (p < 3) ? 26 : (p < 6) ? 58 : 0;
            stall_pct = (p < 3) ? 58 : (p < 6) ? 26 : 0;
            n = (phase_cells[p] > CELL_COUNT) ? CELL_COUNT : int'(phase_cells[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2)
                    drain(0);
                // An estimate may only go out once every cell it sums has been loaded.
                ready = 1'b1;
                next_free = 0;
                for (int c = 0; c < n; c++) begin
                    if (!cell_loaded[c]) begin
                        ready = 1'b0;
                        next_free = c;
                        break;
                    end
                end
                if (ready && $urandom_range(0, 2) == 0) begin
                    send_item(wlum_pkg::OP_ESTIMATE, 7'($urandom), 8'($urandom),
                              8'($urandom), pick_gain());
                end else begin
                    if (!ready && $urandom_range(0, 7) != 0)
                        idx = next_free;
                    else if (n > 0 && $urandom_range(0, 3) != 0)
                        idx = $urandom_range(0, n - 1);
                    else
                        idx = $urandom_range(0, CELL_COUNT - 1);
                    send_item(wlum_pkg::OP_LOAD, 7'(idx), pick_level(), pick_level(),
                              16'($urandom));
                end
            end
        end

        send_idle_pct = 0;
        drain(SETTLE_CYCLES);
        if (meter.mismatch_count == 0 && meter.lum_due.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
